### rtl/core/arl_pkg.sv
package arl_pkg;

    // Fixed field widths of one input and one result word.
    localparam int ADDR_W    = 64;
    localparam int LEN_W     = 32;
    localparam int OUT_IDX_W = 6;

    // The token index is wide enough for the largest supported table (256 entries).
    localparam int TOK_IDX_W = 8;

    // Command codes of an input word.
    typedef enum logic [1:0] {
        CMD_CLEAR       = 2'd0,
        CMD_APPEND_PRIO = 2'd1,
        CMD_APPEND_REG  = 2'd2,
        CMD_LOOKUP      = 2'd3
    } t_cmd;

    // Search token handed from cell to cell along a table chain.
    typedef struct packed {
        logic                 vld;
        logic                 hit;
        logic [TOK_IDX_W-1:0] idx;
    } t_tok;

endpackage

### rtl/core/arl_cell.sv
module arl_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [arl_pkg::ADDR_W-1:0]  i_wr_base,
    input  logic [arl_pkg::LEN_W-1:0]   i_wr_len,
    input  logic                        i_entry_valid,
    input  logic [arl_pkg::ADDR_W-1:0]  i_addr,
    input  arl_pkg::t_tok               i_tok,
    output arl_pkg::t_tok               o_tok
);
    import arl_pkg::*;

    logic [ADDR_W-1:0] r_base;
    logic [LEN_W-1:0]  r_len;
    t_tok              r_tok;
    t_tok              n_tok;
    logic [ADDR_W-1:0] offset;
    logic              match;

    // Entry storage, written once per append into this slot.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_base <= i_wr_base;
            r_len  <= i_wr_len;
        end
    end

    // Range check: base <= addr and addr - base < length, so the end never wraps.
    assign offset = i_addr - r_base;
    assign match  = i_entry_valid && (i_addr >= r_base)
                    && (offset < {{(ADDR_W-LEN_W){1'b0}}, r_len});

    // An earlier hit in the chain wins; otherwise this cell claims the token.
    always_comb begin
        n_tok.vld = i_tok.vld;
        n_tok.hit = i_tok.hit | match;
        n_tok.idx = i_tok.hit ? i_tok.idx : TOK_IDX_W'(CELL_INDEX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

### rtl/core/arl_chain.sv
module arl_chain #(
    parameter int ENTRIES = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic                           i_append,
    input  logic [arl_pkg::ADDR_W-1:0]     i_base,
    input  logic [arl_pkg::LEN_W-1:0]      i_len,
    input  logic [arl_pkg::ADDR_W-1:0]     i_addr,
    input  arl_pkg::t_tok                  i_tok,
    output arl_pkg::t_tok                  o_tok,
    output logic                           o_full,
    output logic [arl_pkg::TOK_IDX_W-1:0]  o_wr_idx
);
    import arl_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    t_tok          links [ENTRIES+1];

    assign o_full   = (r_count == CW'(ENTRIES));
    assign o_wr_idx = TOK_IDX_W'(r_count);

    // Fill count: clear drops it to zero, an accepted append bumps it.
    always_comb begin
        n_count = r_count;
        if (i_clear) begin
            n_count = '0;
        end else if (i_append && !o_full) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Row of cells; the token moves one cell per cycle.
    assign links[0] = i_tok;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        arl_cell #(
            .CELL_INDEX(g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_wr_en       (i_append && !o_full && (r_count == CW'(g))),
            .i_wr_base     (i_base),
            .i_wr_len      (i_len),
            .i_entry_valid (CW'(g) < r_count),
            .i_addr        (i_addr),
            .i_tok         (links[g]),
            .o_tok         (links[g+1])
        );
    end

    assign o_tok = links[ENTRIES];

endmodule

### rtl/core/address_range_lookup_table_top.sv
// Clear and append words strobe their result in the next cycle,
// and a new word may be started every cycle while busy is low.
// A lookup keeps busy high while its token walks both cell chains, one cell per cycle;
// its result strobes just after.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Synchronous active-low reset empties both tables at once; no clearing pass is needed.
module address_range_lookup_table_top #(
    parameter int PRIORITY_ENTRIES = 8,
    parameter int REGULAR_ENTRIES  = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_cmd,
    input  logic [arl_pkg::ADDR_W-1:0]    i_address,
    input  logic [arl_pkg::LEN_W-1:0]     i_range_size,
    output logic                          o_strobe,
    output logic                          o_found,
    output logic                          o_from_priority,
    output logic [arl_pkg::OUT_IDX_W-1:0] o_entry_index,
    output logic                          o_table_full
);
    import arl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } t_state;

    t_state               r_state, n_state;
    logic                 r_go, n_go;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic                 r_p_done, n_p_done, r_r_done, n_r_done;
    logic                 r_p_hit, n_p_hit, r_r_hit, n_r_hit;
    logic [TOK_IDX_W-1:0] r_p_idx, n_p_idx, r_r_idx, n_r_idx;
    logic                 r_strobe, n_strobe;
    logic                 r_found, n_found;
    logic                 r_prio, n_prio;
    logic [OUT_IDX_W-1:0] r_idx, n_idx;
    logic                 r_full, n_full;

    logic                 accept;
    t_tok                 tok_in, p_tok, r_tok;
    logic                 p_full, r_tbl_full;
    logic [TOK_IDX_W-1:0] p_wr_idx, r_wr_idx;
    logic                 p_done, r_done, p_hit, r_hit;
    logic [TOK_IDX_W-1:0] p_idx, r_idx_now;

    assign busy   = (r_state == ST_SEARCH);
    assign accept = start && !busy;

    // One token enters both chains together, the cycle after a lookup is accepted.
    assign tok_in = '{vld: r_go, hit: 1'b0, idx: '0};

    arl_chain #(
        .ENTRIES(PRIORITY_ENTRIES)
    ) u_prio (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (accept && (i_cmd == CMD_CLEAR)),
        .i_append (accept && (i_cmd == CMD_APPEND_PRIO)),
        .i_base   (i_address),
        .i_len    (i_range_size),
        .i_addr   (r_addr),
        .i_tok    (tok_in),
        .o_tok    (p_tok),
        .o_full   (p_full),
        .o_wr_idx (p_wr_idx)
    );

    arl_chain #(
        .ENTRIES(REGULAR_ENTRIES)
    ) u_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (accept && (i_cmd == CMD_CLEAR)),
        .i_append (accept && (i_cmd == CMD_APPEND_REG)),
        .i_base   (i_address),
        .i_len    (i_range_size),
        .i_addr   (r_addr),
        .i_tok    (tok_in),
        .o_tok    (r_tok),
        .o_full   (r_tbl_full),
        .o_wr_idx (r_wr_idx)
    );

    // The shorter chain finishes first; its outcome is held until the other arrives.
    assign p_done    = r_p_done | p_tok.vld;
    assign r_done    = r_r_done | r_tok.vld;
    assign p_hit     = r_p_done ? r_p_hit : p_tok.hit;
    assign r_hit     = r_r_done ? r_r_hit : r_tok.hit;
    assign p_idx     = r_p_done ? r_p_idx : p_tok.idx;
    assign r_idx_now = r_r_done ? r_r_idx : r_tok.idx;

    // Command decode and result word.
    always_comb begin
        n_state  = r_state;
        n_go     = 1'b0;
        n_addr   = r_addr;
        n_p_done = r_p_done;
        n_r_done = r_r_done;
        n_p_hit  = r_p_hit;
        n_r_hit  = r_r_hit;
        n_p_idx  = r_p_idx;
        n_r_idx  = r_r_idx;
        n_strobe = 1'b0;
        n_found  = r_found;
        n_prio   = r_prio;
        n_idx    = r_idx;
        n_full   = r_full;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_CLEAR: begin
                            n_strobe = 1'b1;
                            n_found  = 1'b0;
                            n_prio   = 1'b0;
                            n_idx    = '0;
                            n_full   = 1'b0;
                        end
                        CMD_APPEND_PRIO: begin
                            n_strobe = 1'b1;
                            n_found  = 1'b0;
                            n_prio   = 1'b1;
                            n_idx    = p_full ? '0 : OUT_IDX_W'(p_wr_idx);
                            n_full   = p_full;
                        end
                        CMD_APPEND_REG: begin
                            n_strobe = 1'b1;
                            n_found  = 1'b0;
                            n_prio   = 1'b0;
                            n_idx    = r_tbl_full ? '0 : OUT_IDX_W'(r_wr_idx);
                            n_full   = r_tbl_full;
                        end
                        CMD_LOOKUP: begin
                            n_state  = ST_SEARCH;
                            n_go     = 1'b1;
                            n_addr   = i_address;
                            n_p_done = 1'b0;
                            n_r_done = 1'b0;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                n_p_done = p_done;
                n_r_done = r_done;
                n_p_hit  = p_hit;
                n_r_hit  = r_hit;
                n_p_idx  = p_idx;
                n_r_idx  = r_idx_now;
                if (p_done && r_done) begin
                    // A priority hit outranks any regular hit.
                    n_state  = ST_IDLE;
                    n_strobe = 1'b1;
                    n_found  = p_hit | r_hit;
                    n_prio   = p_hit;
                    n_full   = 1'b0;
                    if (p_hit) begin
                        n_idx = OUT_IDX_W'(p_idx);
                    end else if (r_hit) begin
                        n_idx = OUT_IDX_W'(r_idx_now);
                    end else begin
                        n_idx = '0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_go     <= 1'b0;
            r_p_done <= 1'b0;
            r_r_done <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_go     <= n_go;
            r_p_done <= n_p_done;
            r_r_done <= n_r_done;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_p_hit <= n_p_hit;
        r_r_hit <= n_r_hit;
        r_p_idx <= n_p_idx;
        r_r_idx <= n_r_idx;
        r_found <= n_found;
        r_prio  <= n_prio;
        r_idx   <= n_idx;
        r_full  <= n_full;
    end

    assign o_strobe        = r_strobe;
    assign o_found         = r_found;
    assign o_from_priority = r_prio;
    assign o_entry_index   = r_idx;
    assign o_table_full    = r_full;

`ifndef ASSERT_OFF
    // An accepted lookup holds off the next word while it searches.
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd == CMD_LOOKUP)) |=> busy)
        else $error("lookup accepted without raising busy");

    // No result can be strobed in the cycle a search token is launched.
    a_go_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_go |-> !o_strobe)
        else $error("result strobed while a search was just launched");

    // A refused append reports slot zero and never a match.
    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_table_full) |-> (!o_found && (o_entry_index == '0)))
        else $error("table full result carries a match or an index");

    // The search ends with exactly one strobe and a return to idle.
    a_search_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("search ended without a result");
`endif

endmodule
